// File: rtl/core/tkhb_pkg.sv
// Shared types and command codes of the tick keyed history buffer.
`default_nettype none
package tkhb_pkg;

	localparam int TICK_W  = 32;
	localparam int CMD_W   = 4;
	localparam int COUNT_W = 6;

	localparam logic [CMD_W-1:0] CMD_STORE_STATE = 4'd0;
	localparam logic [CMD_W-1:0] CMD_STORE_INPUT = 4'd1;
	localparam logic [CMD_W-1:0] CMD_GET_STATE   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_GET_INPUT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DISCARD     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_CONTIG      = 4'd5;
	localparam logic [CMD_W-1:0] CMD_STATE_RANGE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_INPUT_RANGE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CLEAR       = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the incoming command
		logic scan;      // run one slot of the current scan
		logic scan_init; // restart the slot scan
		logic commit;    // apply the store / discard / clear at the end of a scan
		logic emit;      // load a result beat into the output register
		logic emit_miss; // result beat is the single "nothing found" beat
	} tkhb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done; // slot scan has passed the last held entry
		logic range_hit; // range scan found a next entry
		logic out_full;  // output register holds an untaken beat
	} tkhb_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/tick_keyed_history_buffer.sv
// Top level of the tick keyed history buffer.
// Keeps up to max_frames entries keyed by tick in insertion order (at most
// DEPTH, and one when max_frames is zero), evicting the earliest inserted on
// a store of a new tick when full. A non-range command is captured, then the
// slot scan walks the held entries one entry a cycle until it sees the end,
// then a commit step and a result step follow before the next beat is taken.
// A range read rescans the held entries once per returned entry plus once
// more to learn that the last one is final, the next-smallest tick being
// found by one compare a cycle. The result register decouples the output; a
// stalled result holds the sequencer. max_frames is written through the cfg
// channel while idle; the user must keep to this, the block does not enforce it.
`default_nettype none
module tick_keyed_history_buffer #(
	parameter int DEPTH   = 32,
	parameter int STATE_W = 64,
	parameter int INPUT_W = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [tkhb_pkg::CMD_W-1:0]           cmd,
	input  wire logic signed [tkhb_pkg::TICK_W-1:0]   tick,
	input  wire logic signed [tkhb_pkg::TICK_W-1:0]   end_tick,
	input  wire logic [STATE_W-1:0]                   state_word,
	input  wire logic [INPUT_W-1:0]                   input_word,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      found,
	output logic signed [tkhb_pkg::TICK_W-1:0]        out_tick,
	output logic [STATE_W-1:0]                        out_state,
	output logic [INPUT_W-1:0]                        out_input,
	output logic signed [tkhb_pkg::TICK_W-1:0]        oldest,
	output logic signed [tkhb_pkg::TICK_W-1:0]        newest,
	output logic [tkhb_pkg::COUNT_W-1:0]              count,
	output logic                                      last,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tkhb_pkg::COUNT_W-1:0]         cfg_data
);

	tkhb_pkg::tkhb_cmd_t ctl;
	tkhb_pkg::tkhb_sts_t sts;
	logic busy, range_q, in_beat;

	// accept a command beat only while the sequencer is idle
	assign in_stall  = busy;
	assign in_beat   = in_valid && !busy;
	assign cfg_ready = 1'b1;

	tkhb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .cmd(cmd),
		.sts(sts), .busy(busy), .ctl(ctl), .range_q(range_q)
	);

	tkhb_dp #(.DEPTH(DEPTH), .STATE_W(STATE_W), .INPUT_W(INPUT_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .range_q(range_q), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data), .cmd(cmd), .tick(tick),
		.end_tick(end_tick), .state_word(state_word), .input_word(input_word),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.out_tick(out_tick), .out_state(out_state), .out_input(out_input),
		.oldest(oldest), .newest(newest), .count(count), .last(last)
	);

endmodule
`default_nettype wire

// File: rtl/core/tkhb_ctrl.sv
// Command sequencer of the tick keyed history buffer.
`default_nettype none
module tkhb_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_beat,
	input  wire logic [tkhb_pkg::CMD_W-1:0] cmd,
	input  wire tkhb_pkg::tkhb_sts_t     sts,
	output logic                         busy,
	output tkhb_pkg::tkhb_cmd_t          ctl,
	output logic                         range_q
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_COMMIT, S_EMIT, S_RSCAN, S_REMIT
	} state_t;

	state_t state_q;
	logic   cand_q;    // a range entry is held back until the next scan tells if it is final

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl = '0;
		ctl.load = in_beat;
		ctl.scan_init = in_beat;
		case (state_q)
			S_SCAN, S_RSCAN: ctl.scan = 1'b1;
			S_COMMIT: ctl.commit = 1'b1;
			S_EMIT: ctl.emit = !sts.out_full;
			S_REMIT: begin
				if (!cand_q) begin
					ctl.scan_init = sts.range_hit;
					ctl.emit = !sts.out_full && !sts.range_hit;
					ctl.emit_miss = 1'b1;
				end else begin
					ctl.emit = !sts.out_full;
					ctl.scan_init = !sts.out_full && sts.range_hit;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			range_q <= 1'b0;
			cand_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_beat) begin
					cand_q <= 1'b0;
					range_q <= (cmd == tkhb_pkg::CMD_STATE_RANGE)
						|| (cmd == tkhb_pkg::CMD_INPUT_RANGE);
					state_q <= ((cmd == tkhb_pkg::CMD_STATE_RANGE)
						|| (cmd == tkhb_pkg::CMD_INPUT_RANGE)) ? S_RSCAN : S_SCAN;
				end
				S_SCAN: if (sts.scan_done) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_EMIT;
				S_EMIT: if (!sts.out_full) state_q <= S_IDLE;
				S_RSCAN: if (sts.scan_done) state_q <= S_REMIT;
				S_REMIT: begin
					if (!cand_q) begin
						if (sts.range_hit) begin
							cand_q <= 1'b1;
							state_q <= S_RSCAN;
						end else if (!sts.out_full) begin
							state_q <= S_IDLE;
						end
					end else if (!sts.out_full) begin
						state_q <= sts.range_hit ? S_RSCAN : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_emit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !sts.out_full) else $error("emit into full output");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> state_q == S_IDLE) else $error("load while busy");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> !ctl.commit) else $error("double commit");
`endif

endmodule
`default_nettype wire

// File: rtl/core/tkhb_dp.sv
// Slot store, scan unit and result register of the tick keyed history buffer.
`default_nettype none
module tkhb_dp #(
	parameter int DEPTH   = 32,
	parameter int STATE_W = 64,
	parameter int INPUT_W = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tkhb_pkg::tkhb_cmd_t             ctl,
	input  wire logic                            range_q,
	output tkhb_pkg::tkhb_sts_t                  sts,
	input  wire logic                            cfg_valid,
	input  wire logic [tkhb_pkg::COUNT_W-1:0]    cfg_data,
	input  wire logic [tkhb_pkg::CMD_W-1:0]      cmd,
	input  wire logic signed [tkhb_pkg::TICK_W-1:0] tick,
	input  wire logic signed [tkhb_pkg::TICK_W-1:0] end_tick,
	input  wire logic [STATE_W-1:0]              state_word,
	input  wire logic [INPUT_W-1:0]              input_word,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 found,
	output logic signed [tkhb_pkg::TICK_W-1:0]   out_tick,
	output logic [STATE_W-1:0]                   out_state,
	output logic [INPUT_W-1:0]                   out_input,
	output logic signed [tkhb_pkg::TICK_W-1:0]   oldest,
	output logic signed [tkhb_pkg::TICK_W-1:0]   newest,
	output logic [tkhb_pkg::COUNT_W-1:0]         count,
	output logic                                 last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TW    = tkhb_pkg::TICK_W;

	// slot arrays; slot 0 is the earliest inserted
	logic signed [TW-1:0] tick_q  [DEPTH];
	logic [DEPTH-1:0]     hs_q, hi_q;
	logic [STATE_W-1:0]   st_mem  [DEPTH];
	logic [INPUT_W-1:0]   in_mem  [DEPTH];
	logic [CNT_W-1:0]     held_q;
	logic signed [TW-1:0] oldest_q, newest_q;
	logic [tkhb_pkg::COUNT_W-1:0] maxf_q;

	// captured command
	logic [tkhb_pkg::CMD_W-1:0] cmd_q;
	logic signed [TW-1:0] t_q, e_q;
	logic [STATE_W-1:0]   sw_q;
	logic [INPUT_W-1:0]   iw_q;

	// scan state
	logic [CNT_W-1:0]     ptr_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [CNT_W-1:0]     cnt_q;        // contiguous count
	logic [DEPTH-1:0]     keep_q;       // discard survivors
	logic [IDX_W-1:0]     dst_q   [DEPTH]; // compaction target of each survivor
	logic [CNT_W-1:0]     rank_q;       // survivors seen so far
	logic                 best_v_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic signed [TW-1:0] best_tick_q;
	logic                 have_prev_q;
	logic signed [TW-1:0] prev_q;       // tick of the range entry held back
	logic [IDX_W-1:0]     cur_idx_q;    // slot of the range entry held back
	logic [CNT_W-1:0]     limit;

	logic out_v_q;
	assign out_valid = out_v_q;
	assign sts.out_full = out_v_q && out_stall;
	assign sts.scan_done = (ptr_q >= held_q);
	assign sts.range_hit = best_v_q;

	always_comb begin
		if (maxf_q == '0) limit = CNT_W'(1);
		else if ({26'd0, maxf_q} > 32'(DEPTH)) limit = CNT_W'(DEPTH);
		else limit = CNT_W'(maxf_q);
	end

	logic [IDX_W-1:0]     pidx;
	logic signed [TW-1:0] ps;
	logic                 phas;
	logic                 want_state;
	assign pidx = ptr_q[IDX_W-1:0];
	assign ps = tick_q[pidx];
	assign want_state = (cmd_q == tkhb_pkg::CMD_STATE_RANGE);
	assign phas = want_state ? hs_q[pidx] : hi_q[pidx];

	// store slot: the hit slot, or the append slot after a possible eviction
	logic               evict;
	logic [CNT_W-1:0]   app;
	logic [IDX_W-1:0]   wslot;
	assign evict = !hit_q && (held_q >= limit) && (held_q != '0);
	assign app = evict ? held_q - CNT_W'(1) : held_q;
	assign wslot = hit_q ? hit_idx_q : app[IDX_W-1:0];

	logic [63:0] span;
	assign span = 64'(e_q) - 64'(t_q) + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
			hi_q <= '0;
			held_q <= '0;
			oldest_q <= '0;
			newest_q <= '0;
			maxf_q <= tkhb_pkg::COUNT_W'(32);
			out_v_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) tick_q[i] <= '0;
		end else begin
			if (cfg_valid) maxf_q <= cfg_data;
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (ctl.emit) out_v_q <= 1'b1;
			if (ctl.commit) begin
				case (cmd_q)
					tkhb_pkg::CMD_STORE_STATE, tkhb_pkg::CMD_STORE_INPUT: begin
						if (evict) begin
							for (int i = 0; i + 1 < DEPTH; i++) begin
								tick_q[i] <= tick_q[i+1];
								hs_q[i] <= hs_q[i+1];
								hi_q[i] <= hi_q[i+1];
							end
						end
						if (!hit_q) begin
							tick_q[wslot] <= t_q;
							held_q <= app + CNT_W'(1);
						end
						if (cmd_q == tkhb_pkg::CMD_STORE_STATE) begin
							hs_q[wslot] <= 1'b1;
							if (!hit_q) hi_q[wslot] <= 1'b0;
							if (t_q > newest_q) newest_q <= t_q;
							if (oldest_q == '0 || t_q < oldest_q) oldest_q <= t_q;
						end else begin
							hi_q[wslot] <= 1'b1;
							if (!hit_q) hs_q[wslot] <= 1'b0;
						end
					end
					tkhb_pkg::CMD_DISCARD: begin
						for (int i = 0; i < DEPTH; i++)
							if (keep_q[i]) begin
								tick_q[dst_q[i]] <= tick_q[i];
								hs_q[dst_q[i]] <= hs_q[i];
								hi_q[dst_q[i]] <= hi_q[i];
							end
						held_q <= rank_q;
						for (int i = 0; i < DEPTH; i++)
							if (keep_q[i] && dst_q[i] == '0)
								oldest_q <= tick_q[i];
					end
					tkhb_pkg::CMD_CLEAR: begin
						hs_q <= '0;
						hi_q <= '0;
						held_q <= '0;
						oldest_q <= '0;
						newest_q <= '0;
						for (int i = 0; i < DEPTH; i++) tick_q[i] <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload memories: shifted on eviction, compacted on discard
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			case (cmd_q)
				tkhb_pkg::CMD_STORE_STATE, tkhb_pkg::CMD_STORE_INPUT: begin
					if (evict)
						for (int i = 0; i + 1 < DEPTH; i++) begin
							st_mem[i] <= st_mem[i+1];
							in_mem[i] <= in_mem[i+1];
						end
					if (cmd_q == tkhb_pkg::CMD_STORE_STATE) st_mem[wslot] <= sw_q;
					else in_mem[wslot] <= iw_q;
				end
				tkhb_pkg::CMD_DISCARD:
					for (int i = 0; i < DEPTH; i++)
						if (keep_q[i]) begin
							st_mem[dst_q[i]] <= st_mem[i];
							in_mem[dst_q[i]] <= in_mem[i];
						end
				default: ;
			endcase
		end
	end

	// command capture and slot scan
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			t_q <= tick;
			e_q <= end_tick;
			sw_q <= state_word;
			iw_q <= input_word;
			have_prev_q <= 1'b0;
		end
		if (ctl.scan_init) begin
			ptr_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			cnt_q <= '0;
			keep_q <= '0;
			rank_q <= '0;
			best_v_q <= 1'b0;
			best_idx_q <= '0;
			best_tick_q <= '0;
		end
		// hold back the entry just found; the next scan decides if it is the final beat
		if (ctl.scan_init && !ctl.load && best_v_q) begin
			have_prev_q <= 1'b1;
			prev_q <= best_tick_q;
			cur_idx_q <= best_idx_q;
		end
		if (ctl.scan && !sts.scan_done) begin
			ptr_q <= ptr_q + CNT_W'(1);
			if (!hit_q && ps == t_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= pidx;
			end
			if (hi_q[pidx] && ps >= t_q && ps <= e_q) cnt_q <= cnt_q + CNT_W'(1);
			keep_q[pidx] <= !(ps < t_q);
			dst_q[pidx] <= rank_q[IDX_W-1:0];
			if (!(ps < t_q)) rank_q <= rank_q + CNT_W'(1);
			if (range_q && phas && ps >= t_q && ps <= e_q
					&& !(have_prev_q && ps <= prev_q)
					&& (!best_v_q || ps < best_tick_q)) begin
				best_v_q <= 1'b1;
				best_idx_q <= pidx;
				best_tick_q <= ps;
			end
		end
		if (ctl.emit) begin
			found <= 1'b0;
			out_tick <= '0;
			out_state <= '0;
			out_input <= '0;
			last <= 1'b1;
			if (range_q) begin
				if (!ctl.emit_miss) begin
					found <= 1'b1;
					out_tick <= prev_q;
					if (want_state) out_state <= st_mem[cur_idx_q];
					else out_input <= in_mem[cur_idx_q];
					last <= !best_v_q;
				end
			end else begin
				case (cmd_q)
					tkhb_pkg::CMD_STORE_STATE, tkhb_pkg::CMD_STORE_INPUT:
						out_tick <= t_q;
					tkhb_pkg::CMD_GET_STATE: begin
						out_tick <= t_q;
						if (hit_q && hs_q[hit_idx_q]) begin
							found <= 1'b1;
							out_state <= st_mem[hit_idx_q];
						end
					end
					tkhb_pkg::CMD_GET_INPUT: begin
						out_tick <= t_q;
						if (hit_q && hi_q[hit_idx_q]) begin
							found <= 1'b1;
							out_input <= in_mem[hit_idx_q];
						end
					end
					tkhb_pkg::CMD_CONTIG:
						found <= (t_q > e_q) || (64'(cnt_q) == span);
					default: ;
				endcase
			end
			oldest <= oldest_q;
			newest <= newest_q;
			count <= tkhb_pkg::COUNT_W'(held_q);
		end
	end

`ifndef ASSERT_OFF
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(DEPTH)) else $error("held above depth");
	a_commit_not_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !range_q) else $error("commit during range read");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_stall |=> out_v_q) else $error("beat lost under stall");
`endif

endmodule
`default_nettype wire
